>>> rtl/sdu_pkg.sv
// Shared types and constants for the serial deframer / unstuffer.
// No dependencies.
`default_nettype none

package sdu_pkg;

    localparam int unsigned ByteW = 8;

    typedef logic [ByteW-1:0] t_byte;

    typedef enum logic {
        REG_FRAME_MARKER  = 1'b0,
        REG_ESCAPE_MARKER = 1'b1
    } t_reg_idx;

    localparam t_byte FRAME_MARKER_RST  = 8'hFE;
    localparam t_byte ESCAPE_MARKER_RST = 8'hFD;
    localparam t_byte ESC_XOR_MASK      = 8'h20;

endpackage

`default_nettype wire

>>> rtl/serial_deframer_unstuffer.sv
// Serial byte deframer with escape removal.
// Depends on sdu_pkg.
//
// Usage:
//   Input channel: one raw received byte per transaction (i_in_valid / o_in_stall).
//   Output channel: one result per transaction (o_out_valid / i_out_stall),
//   carrying a payload byte, an end-of-frame flag and an escape error flag.
//   A frame marker closes the frame; the last payload byte is held back so it
//   leaves with end_of_frame set. Empty frames produce nothing, unless they end in a
//   dangling escape, which gives a byte-less result with the escape error flag set.
//   Config: i_cfg_we writes i_cfg_data to register i_cfg_idx
//   (0 frame marker, 1 escape marker); write only while idle.
//   One byte accepted per cycle sustained while the output is not stalled. A byte
//   is registered in the input register, then the per-byte compare/update logic
//   loads the result register from it.
// Reset:
//   Markers return to 0xFE / 0xFD, pipeline empties, and all bytes up to
//   and including the first frame marker are discarded.
// Stall:
//   While the result register is stalled, the input register holds and
//   o_in_stall rises once it is occupied; nothing is dropped.
`default_nettype none

module serial_deframer_unstuffer (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_in_valid,
    output logic              o_in_stall,
    input  wire sdu_pkg::t_byte i_rx_byte,
    output logic              o_out_valid,
    input  wire               i_out_stall,
    output sdu_pkg::t_byte    o_frame_byte,
    output logic              o_has_byte,
    output logic              o_end_of_frame,
    output logic              o_escape_error,
    input  wire               i_cfg_we,
    input  wire sdu_pkg::t_reg_idx i_cfg_idx,
    input  wire sdu_pkg::t_byte i_cfg_data
);
    import sdu_pkg::*;

    t_byte r_frame_marker;
    t_byte r_escape_marker;

    logic  r_in_valid;
    t_byte r_in_byte;

    logic  r_hunt, n_hunt;
    logic  r_esc, n_esc;
    logic  r_held_v, n_held_v;
    t_byte r_held, n_held;

    logic  r_out_valid;
    t_byte r_out_byte;
    logic  r_out_has, r_out_eof, r_out_err;

    logic  res_v, res_has, res_eof, res_err;
    t_byte res_byte;
    logic  adv, proc;

    assign adv        = !r_out_valid || !i_out_stall;
    assign proc       = r_in_valid && adv;
    assign o_in_stall = r_in_valid && !adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_marker  <= FRAME_MARKER_RST;
            r_escape_marker <= ESCAPE_MARKER_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_FRAME_MARKER:  r_frame_marker  <= i_cfg_data;
                REG_ESCAPE_MARKER: r_escape_marker <= i_cfg_data;
                default:           r_frame_marker  <= r_frame_marker;
            endcase
        end
    end

    always_comb begin
        n_hunt   = r_hunt;
        n_esc    = r_esc;
        n_held_v = r_held_v;
        n_held   = r_held;
        res_v    = 1'b0;
        res_byte = '0;
        res_has  = 1'b0;
        res_eof  = 1'b0;
        res_err  = 1'b0;
        if (r_hunt) begin
            if (r_in_byte == r_frame_marker) n_hunt = 1'b0;
        end else if (r_in_byte == r_frame_marker) begin
            if (r_held_v) begin
                res_v    = 1'b1;
                res_byte = r_held;
                res_has  = 1'b1;
                res_eof  = 1'b1;
                res_err  = r_esc;
            end else if (r_esc) begin
                res_v   = 1'b1;
                res_eof = 1'b1;
                res_err = 1'b1;
            end
            n_held_v = 1'b0;
            n_held   = '0;
            n_esc    = 1'b0;
        end else if (!r_esc && r_in_byte == r_escape_marker) begin
            n_esc = 1'b1;
        end else begin
            if (r_held_v) begin
                res_v    = 1'b1;
                res_byte = r_held;
                res_has  = 1'b1;
            end
            n_held   = r_esc ? (r_in_byte ^ ESC_XOR_MASK) : r_in_byte;
            n_held_v = 1'b1;
            n_esc    = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_hunt      <= 1'b1;
            r_esc       <= 1'b0;
            r_held_v    <= 1'b0;
            r_held      <= '0;
        end else begin
            if (!o_in_stall) r_in_valid <= i_in_valid;
            if (adv) r_out_valid <= proc && res_v;
            if (proc) begin
                r_hunt   <= n_hunt;
                r_esc    <= n_esc;
                r_held_v <= n_held_v;
                r_held   <= n_held;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) r_in_byte <= i_rx_byte;
        if (adv) begin
            r_out_byte <= res_byte;
            r_out_has  <= res_has;
            r_out_eof  <= res_eof;
            r_out_err  <= res_err;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_frame_byte   = r_out_byte;
    assign o_has_byte     = r_out_has;
    assign o_end_of_frame = r_out_eof;
    assign o_escape_error = r_out_err;

    a_err_only_at_eof: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_err |-> r_out_eof)
        else $error("escape error without end of frame");

    a_empty_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out_has |-> r_out_byte == '0 && r_out_eof && r_out_err)
        else $error("byte-less result malformed");

    a_hunt_no_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hunt |-> !r_esc && !r_held_v)
        else $error("frame state active while hunting");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !adv |=> r_in_valid && $stable(r_in_byte))
        else $error("input register lost a byte under stall");

endmodule

`default_nettype wire
